// ===== rtl/kti_pkg.sv =====
// shared types and constants for the keyframe track interpolator
`timescale 1ns / 1ps
package kti_pkg;

  localparam int unsigned MAX_BONES_DEF   = 64;
  localparam int unsigned MAX_KEYS_DEF    = 32;
  localparam logic [31:0] PERIOD_RST      = 32'h0001_0000;
  localparam logic [31:0] ONE_Q16         = 32'h0001_0000;
  localparam int unsigned FRAMES_PER_UNIT = 30;
  localparam logic [15:0] FRAC_MAX        = 16'hFFFF;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;
  localparam logic TRACK_SCALE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic        track;
    logic [5:0]  bone;
    logic [4:0]  key_index;
    logic        key_last;
    logic [23:0] key_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [31:0] delta_time;
    logic [15:0] speed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [4:0]  key_begin;
    logic [4:0]  key_next;
    logic [15:0] fraction;
    logic        empty_res;
  } out_t;

  typedef struct packed {
    logic [23:0] ktime;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } key_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT,
    S_MOD,
    S_MUL,
    S_SCALE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD_B,
    S_RD_N,
    S_GOT_N,
    S_DIV,
    S_BL_MUL,
    S_BL_ADD,
    S_DONE
  } state_e;

endpackage

// ===== rtl/kti_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module kti_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/keyframe_track_interpolator.sv =====
// keyframe track interpolator: key store, backward search and linear blend
// loads are taken back to back while busy is low and write the key store at the accept edge
// a sample reads the key count, wraps the time by the period unless the period is zero,
// scales it, searches the keys backward, reads the begin and next keys, divides for the
// fraction when it needs the divide and blends x, y, z in turn; an empty track strobes after the count read
// busy stays high through the strobe cycle, the next item can be taken in the following cycle;
// done_o is high for one cycle and cannot be held off
// after reset the key count store is cleared with busy high
`timescale 1ns / 1ps
module keyframe_track_interpolator #(
  parameter int unsigned MAX_BONES = kti_pkg::MAX_BONES_DEF,
  parameter int unsigned MAX_KEYS  = kti_pkg::MAX_KEYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kti_pkg::in_t  item_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  output logic          done_o,
  output kti_pkg::out_t result_o
);

  localparam int unsigned NTRACKS = 2 * MAX_BONES;
  localparam int unsigned NSLOTS  = NTRACKS * MAX_KEYS;
  localparam int unsigned TW      = $clog2(NTRACKS);
  localparam int unsigned KW      = $clog2(MAX_KEYS);
  localparam int unsigned CW      = $clog2(MAX_KEYS + 1);
  localparam int unsigned AW      = $clog2(NSLOTS);
  localparam int unsigned KEYW    = $bits(kti_pkg::key_t);

  kti_pkg::state_e state_q, state_d;
  logic [TW-1:0]   clr_q, clr_d;
  logic [31:0]     period_q, period_d;

  kti_pkg::in_t    item_q, item_d;
  kti_pkg::out_t   res_q, res_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [KW-1:0]   begin_q, begin_d;
  logic [KW-1:0]   next_q, next_d;
  logic            found_q, found_d;
  logic [31:0]     t_q, t_d;
  logic [52:0]     ft_q, ft_d;
  logic [23:0]     tb_q, tb_d;
  logic [15:0]     frac_q, frac_d;
  logic [31:0]     vb_q [3];
  logic [31:0]     vb_d [3];
  logic [31:0]     vn_q [3];
  logic [31:0]     vn_d [3];
  logic [1:0]      comp_q, comp_d;
  logic [4:0]      step_q, step_d;
  logic [40:0]     rem_q, rem_d;
  logic [40:0]     div_q, div_d;
  logic [31:0]     quo_q, quo_d;
  logic signed [50:0] mul_q, mul_d;

  // shared divide step unit
  logic        div_bin;
  logic [40:0] r_sh, r_nx;
  logic        r_ge;
  logic [31:0] quo_nx;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic [16:0]        mul_b;
  logic signed [50:0] mul_p;

  // store ports
  logic               accept;
  logic [TW-1:0]      tr_in;
  logic               in_range;
  logic               key_we;
  logic [AW-1:0]      key_waddr;
  logic [AW-1:0]      key_raddr;
  kti_pkg::key_t      key_wdata, key_rd;
  logic [KEYW-1:0]    key_rdata;
  logic               cnt_we;
  logic [TW-1:0]      cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic [CW-1:0]      cnt_rdata;

  assign accept   = start && !busy;
  assign tr_in    = TW'(32'(item_i.bone) * 2 + 32'(item_i.track));
  assign in_range = (32'(item_i.bone) < MAX_BONES) && (32'(item_i.key_index) < MAX_KEYS);
  assign key_we   = accept && (item_i.cmd == kti_pkg::CMD_LOAD) && in_range;
  assign key_waddr = AW'(32'(tr_in) * MAX_KEYS + 32'(item_i.key_index));
  assign key_wdata = '{ktime: item_i.key_time, vx: item_i.value_x,
                       vy: item_i.value_y, vz: item_i.value_z};
  assign key_rd    = kti_pkg::key_t'(key_rdata);

  assign cnt_we    = (state_q == kti_pkg::S_CLEAR) || (key_we && item_i.key_last);
  assign cnt_waddr = (state_q == kti_pkg::S_CLEAR) ? clr_q : tr_in;
  assign cnt_wdata = (state_q == kti_pkg::S_CLEAR) ? '0
                   : CW'(32'(item_i.key_index) + 1);

  kti_ram #(.WIDTH(KEYW), .DEPTH(NSLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  kti_ram #(.WIDTH(CW), .DEPTH(NTRACKS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (tr_in),
    .rdata_o (cnt_rdata)
  );

  assign div_bin = (state_q == kti_pkg::S_MOD) ? quo_q[31] : 1'b0;
  assign r_sh    = {rem_q[39:0], div_bin};
  assign r_ge    = r_sh >= div_q;
  assign r_nx    = r_ge ? r_sh - div_q : r_sh;
  assign quo_nx  = {quo_q[30:0], r_ge};

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  assign busy     = state_q != kti_pkg::S_IDLE;
  assign done_o   = state_q == kti_pkg::S_DONE;
  assign result_o = res_q;

  always_comb begin
    case (state_q)
      kti_pkg::S_SRCH_RD: key_raddr = base_q + AW'(idx_q - CW'(1));
      kti_pkg::S_RD_B:    key_raddr = base_q + AW'(begin_q);
      kti_pkg::S_RD_N:    key_raddr = base_q + AW'(next_q);
      default:            key_raddr = base_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    period_d = cfg_we_i ? cfg_wdata_i : period_q;
    item_d   = item_q;
    res_d    = res_q;
    base_d   = base_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    begin_d  = begin_q;
    next_d   = next_q;
    found_d  = found_q;
    t_d      = t_q;
    ft_d     = ft_q;
    tb_d     = tb_q;
    frac_d   = frac_q;
    vb_d     = vb_q;
    vn_d     = vn_q;
    comp_d   = comp_q;
    step_d   = step_q;
    rem_d    = rem_q;
    div_d    = div_q;
    quo_d    = quo_q;
    mul_d    = mul_q;
    mul_a    = {1'b0, t_q};
    mul_b    = {1'b0, item_q.speed};

    case (state_q)
      kti_pkg::S_CLEAR: begin
        clr_d = clr_q + TW'(1);
        if (32'(clr_q) == NTRACKS - 1) begin
          state_d = kti_pkg::S_IDLE;
        end
      end
      kti_pkg::S_IDLE: begin
        if (accept && item_i.cmd == kti_pkg::CMD_SAMPLE) begin
          item_d  = item_i;
          base_d  = AW'(32'(tr_in) * MAX_KEYS);
          state_d = kti_pkg::S_CNT;
        end
      end
      kti_pkg::S_CNT: begin
        if (32'(item_q.bone) >= MAX_BONES || cnt_rdata == '0) begin
          res_d.out_x     = (item_q.track == kti_pkg::TRACK_SCALE) ? kti_pkg::ONE_Q16 : '0;
          res_d.out_y     = res_d.out_x;
          res_d.out_z     = res_d.out_x;
          res_d.key_begin = '0;
          res_d.key_next  = '0;
          res_d.fraction  = '0;
          res_d.empty_res = 1'b1;
          state_d = kti_pkg::S_DONE;
        end else begin
          cnt_d  = cnt_rdata;
          rem_d  = '0;
          div_d  = 41'(period_q);
          quo_d  = item_q.delta_time;
          step_d = '0;
          if (period_q == '0) begin
            t_d     = item_q.delta_time;
            state_d = kti_pkg::S_MUL;
          end else begin
            state_d = kti_pkg::S_MOD;
          end
        end
      end
      kti_pkg::S_MOD: begin
        // one remainder bit per cycle
        rem_d  = r_nx;
        quo_d  = quo_nx;
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          t_d     = r_nx[31:0];
          state_d = kti_pkg::S_MUL;
        end
      end
      kti_pkg::S_MUL: begin
        mul_d   = mul_p;
        state_d = kti_pkg::S_SCALE;
      end
      kti_pkg::S_SCALE: begin
        ft_d    = 53'(mul_q[47:0]) * 53'(kti_pkg::FRAMES_PER_UNIT);
        idx_d   = cnt_q;
        state_d = kti_pkg::S_SRCH_RD;
      end
      kti_pkg::S_SRCH_RD: begin
        state_d = kti_pkg::S_SRCH_CMP;
      end
      kti_pkg::S_SRCH_CMP: begin
        if (ft_q >= 53'({key_rd.ktime, 16'h0})) begin
          begin_d = KW'(idx_q - CW'(1));
          found_d = 1'b1;
          state_d = kti_pkg::S_RD_B;
        end else if (idx_q == CW'(1)) begin
          begin_d = '0;
          found_d = 1'b0;
          state_d = kti_pkg::S_RD_B;
        end else begin
          idx_d   = idx_q - CW'(1);
          state_d = kti_pkg::S_SRCH_RD;
        end
        if (32'(begin_d) + 1 < 32'(cnt_q)) begin
          next_d = begin_d + KW'(1);
        end else begin
          next_d = begin_d;
        end
      end
      kti_pkg::S_RD_B: begin
        state_d = kti_pkg::S_RD_N;
      end
      kti_pkg::S_RD_N: begin
        tb_d    = key_rd.ktime;
        vb_d[0] = key_rd.vx;
        vb_d[1] = key_rd.vy;
        vb_d[2] = key_rd.vz;
        state_d = kti_pkg::S_GOT_N;
      end
      kti_pkg::S_GOT_N: begin
        vn_d[0] = key_rd.vx;
        vn_d[1] = key_rd.vy;
        vn_d[2] = key_rd.vz;
        frac_d  = '0;
        comp_d  = '0;
        state_d = kti_pkg::S_BL_MUL;
        if (found_q && next_q != begin_q && key_rd.ktime > tb_q) begin
          if (ft_q >= 53'({key_rd.ktime, 16'h0})) begin
            frac_d = kti_pkg::FRAC_MAX;
          end else begin
            // remainder starts below the divisor, so the quotient fits 16 bits
            rem_d   = 41'(ft_q - 53'({tb_q, 16'h0}));
            div_d   = 41'({key_rd.ktime - tb_q, 16'h0});
            quo_d   = '0;
            step_d  = '0;
            state_d = kti_pkg::S_DIV;
          end
        end
      end
      kti_pkg::S_DIV: begin
        rem_d  = r_nx;
        quo_d  = quo_nx;
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          frac_d  = quo_nx[15:0];
          state_d = kti_pkg::S_BL_MUL;
        end
      end
      kti_pkg::S_BL_MUL: begin
        mul_a   = $signed({vn_q[comp_q][31], vn_q[comp_q]})
                - $signed({vb_q[comp_q][31], vb_q[comp_q]});
        mul_b   = {1'b0, frac_q};
        mul_d   = mul_p;
        state_d = kti_pkg::S_BL_ADD;
      end
      kti_pkg::S_BL_ADD: begin
        // vb + floor((vn - vb) * f / 2^16)
        case (comp_q)
          2'd0:    res_d.out_x = vb_q[0] + 32'(mul_q >>> 16);
          2'd1:    res_d.out_y = vb_q[1] + 32'(mul_q >>> 16);
          default: res_d.out_z = vb_q[2] + 32'(mul_q >>> 16);
        endcase
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          res_d.key_begin = 5'(begin_q);
          res_d.key_next  = 5'(next_q);
          res_d.fraction  = frac_q;
          res_d.empty_res = 1'b0;
          state_d = kti_pkg::S_DONE;
        end else begin
          state_d = kti_pkg::S_BL_MUL;
        end
      end
      kti_pkg::S_DONE: begin
        state_d = kti_pkg::S_IDLE;
      end
      default: begin
        state_d = kti_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kti_pkg::S_CLEAR;
      clr_q    <= '0;
      period_q <= kti_pkg::PERIOD_RST;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      period_q <= period_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    res_q   <= res_d;
    base_q  <= base_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    begin_q <= begin_d;
    next_q  <= next_d;
    found_q <= found_d;
    t_q     <= t_d;
    ft_q    <= ft_d;
    tb_q    <= tb_d;
    frac_q  <= frac_d;
    vb_q    <= vb_d;
    vn_q    <= vn_d;
    comp_q  <= comp_d;
    step_q  <= step_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    quo_q   <= quo_d;
    mul_q   <= mul_d;
  end

endmodule

// ===== dv/keyframe_track_interpolator_tb.sv =====
// self-checking testbench for the keyframe track interpolator
`timescale 1ns / 1ps
module keyframe_track_interpolator_tb;

  localparam int unsigned NTRK      = kti_pkg::MAX_BONES_DEF * 2;
  localparam int unsigned NSLOT     = NTRK * kti_pkg::MAX_KEYS_DEF;
  localparam int unsigned DRAIN_CYC = 300;
  localparam int unsigned WDOG_LIM  = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  kti_pkg::in_t  item_i = '0;
  logic          cfg_we_i = 1'b0;
  logic [31:0]   cfg_wdata_i = '0;
  logic          done_o;
  kti_pkg::out_t result_o;

  keyframe_track_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the key store and the period register
  logic [23:0] key_time_mem [0:NSLOT-1];
  logic [31:0] key_x_mem    [0:NSLOT-1];
  logic [31:0] key_y_mem    [0:NSLOT-1];
  logic [31:0] key_z_mem    [0:NSLOT-1];
  logic [5:0]  key_cnt      [0:NTRK-1];
  logic [31:0] period_q = kti_pkg::PERIOD_RST;

  kti_pkg::in_t  pending_items [$];
  kti_pkg::out_t expected_samples [$];
  int   send_idle_pct = 15;
  int   n_errors = 0;
  logic took = 1'b0;

  // generator's view of which slots hold a key, so that no unwritten key is read
  bit          gen_written [0:NSLOT-1];
  int unsigned last_bone = 0;

  function automatic logic [31:0] blend_q16(logic signed [31:0] a, logic signed [31:0] b,
                                            logic [15:0] f);
    longint s;
    s = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f);
    return 32'(s >>> 16);
  endfunction

  function automatic kti_pkg::out_t sample_track(kti_pkg::in_t it);
    kti_pkg::out_t r;
    int unsigned tr;
    int unsigned base;
    int unsigned cnt;
    logic [31:0] t;
    logic [63:0] ft;
    logic [63:0] tb;
    logic [63:0] tn;
    logic [63:0] q;
    int unsigned kb;
    int unsigned kn;
    bit          found;
    r = '0;
    tr = 32'({it.bone, it.track});
    cnt = 32'(key_cnt[tr]);
    if (cnt == 0) begin
      r.out_x = (it.track == kti_pkg::TRACK_SCALE) ? kti_pkg::ONE_Q16 : '0;
      r.out_y = r.out_x;
      r.out_z = r.out_x;
      r.empty_res = 1'b1;
      return r;
    end
    base = tr * kti_pkg::MAX_KEYS_DEF;
    t = (period_q != 0) ? it.delta_time % period_q : it.delta_time;
    ft = 64'(t) * 64'(it.speed) * 64'(kti_pkg::FRAMES_PER_UNIT);
    kb = 0;
    found = 0;
    for (int unsigned i = cnt; i > 0; i--) begin
      if (!found && ft >= (64'(key_time_mem[base + i - 1]) << 16)) begin
        kb = i - 1;
        found = 1;
      end
    end
    kn = (kb + 1 < cnt) ? kb + 1 : kb;
    r.fraction = '0;
    if (found && kn != kb) begin
      tb = 64'(key_time_mem[base + kb]) << 16;
      tn = 64'(key_time_mem[base + kn]) << 16;
      if (tn > tb) begin
        if (ft >= tn) begin
          r.fraction = kti_pkg::FRAC_MAX;
        end else begin
          q = ((ft - tb) << 16) / (tn - tb);
          r.fraction = (q > 65535) ? kti_pkg::FRAC_MAX : q[15:0];
        end
      end
    end
    r.out_x = blend_q16(key_x_mem[base + kb], key_x_mem[base + kn], r.fraction);
    r.out_y = blend_q16(key_y_mem[base + kb], key_y_mem[base + kn], r.fraction);
    r.out_z = blend_q16(key_z_mem[base + kb], key_z_mem[base + kn], r.fraction);
    r.key_begin = kb[4:0];
    r.key_next = kn[4:0];
    return r;
  endfunction

  task automatic apply_item(kti_pkg::in_t it);
    int unsigned slot;
    slot = 32'({it.bone, it.track, it.key_index});
    if (it.cmd == kti_pkg::CMD_LOAD) begin
      key_time_mem[slot] = it.key_time;
      key_x_mem[slot] = it.value_x;
      key_y_mem[slot] = it.value_y;
      key_z_mem[slot] = it.value_z;
      if (it.key_last) key_cnt[{it.bone, it.track}] = 6'(32'(it.key_index) + 1);
    end else begin
      expected_samples.push_back(sample_track(it));
    end
  endtask

  task automatic check_result(kti_pkg::out_t got);
    kti_pkg::out_t exp_r;
    bit   bad;
    if (expected_samples.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = expected_samples.pop_front();
    bad = (got.out_x !== exp_r.out_x) || (got.out_y !== exp_r.out_y) ||
          (got.out_z !== exp_r.out_z) || (got.key_begin !== exp_r.key_begin) ||
          (got.key_next !== exp_r.key_next) || (got.fraction !== exp_r.fraction) ||
          (got.empty_res !== exp_r.empty_res);
    if (bad) begin
      n_errors++;
      if (n_errors <= 10) $display("result differs: expected %p got %p", exp_r, got);
    end
  endtask

  // monitor: results first, then the item taken at this edge
  always @(posedge clk_i) begin
    took <= start && !busy;
    if (rst_ni) begin
      if (done_o) check_result(result_o);
      if (start && !busy) apply_item(item_i);
    end
  end

  // driver: hold an item until taken, then maybe idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      item_i <= pending_items.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // watchdog on cycles with nothing accepted and no result
  int unsigned quiet_cyc = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WDOG_LIM) begin
      $display("keyframe_track_interpolator: mismatch");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  function automatic kti_pkg::in_t rand_item();
    kti_pkg::in_t it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(kti_pkg::in_t)-1:0];
    return it;
  endfunction

  task automatic push_load(int unsigned bone, bit trk, int unsigned kidx, bit last,
                           logic [23:0] ktime);
    kti_pkg::in_t it;
    it = rand_item();
    it.cmd = kti_pkg::CMD_LOAD;
    it.bone = 6'(bone);
    it.track = trk;
    it.key_index = 5'(kidx);
    it.key_last = last;
    it.key_time = ktime;
    gen_written[{it.bone, it.track, it.key_index}] = 1;
    pending_items.push_back(it);
  endtask

  task automatic push_sample(int unsigned bone, bit trk, logic [31:0] dt, logic [15:0] spd);
    kti_pkg::in_t it;
    it = rand_item();
    it.cmd = kti_pkg::CMD_SAMPLE;
    it.bone = 6'(bone);
    it.track = trk;
    it.delta_time = dt;
    it.speed = spd;
    pending_items.push_back(it);
  endtask

  // one well-formed track: keys 0..n-1, mostly ascending, some coinciding
  task automatic push_track(int unsigned bone, bit trk, int unsigned n);
    int unsigned kt;
    kt = $urandom_range(0, 2000);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) push_load(bone, trk, k, k == n - 1, 24'($urandom));
      else push_load(bone, trk, k, k == n - 1, 24'(kt));
      kt += ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 3000);
    end
  endtask

  task automatic push_random_sample();
    int unsigned bone;
    bone = $urandom_range(1) ? last_bone : $urandom_range(63);
    if ($urandom_range(4) == 0)
      push_sample(bone, 1'($urandom), $urandom, 16'($urandom));
    else
      push_sample(bone, 1'($urandom), $urandom_range(0, 32'h3FFFF),
                  16'($urandom_range(0, 1024)));
  endtask

  // stray load; the count is only moved when all lower slots hold keys
  task automatic push_stray_load();
    int unsigned bone;
    int unsigned kidx;
    bit          trk;
    bit          last;
    bit          ok;
    bone = $urandom_range(63);
    trk = 1'($urandom);
    kidx = $urandom_range(31);
    ok = 1;
    for (int unsigned k = 0; k < kidx; k++) if (!gen_written[{6'(bone), trk, 5'(k)}]) ok = 0;
    last = ok && $urandom_range(1);
    push_load(bone, trk, kidx, last, 24'($urandom));
  endtask

  task automatic run_random(int unsigned n);
    int unsigned cnt;
    int unsigned r;
    int unsigned len;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 20) begin
        last_bone = $urandom_range(63);
        len = ($urandom_range(7) == 0) ? 32 : $urandom_range(1, 8);
        push_track(last_bone, 1'($urandom), len);
        cnt += len;
      end else if (r < 88) begin
        push_random_sample();
        cnt++;
      end else begin
        push_stray_load();
        cnt++;
      end
    end
  endtask

  task automatic settle();
    wait (pending_items.size() == 0 && !start && expected_samples.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_period(logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    period_q = val;
  endtask

  initial begin
    for (int i = 0; i < NTRK; i++) key_cnt[i] = '0;
    for (int i = 0; i < NSLOT; i++) begin
      key_time_mem[i] = '0;
      key_x_mem[i] = '0;
      key_y_mem[i] = '0;
      key_z_mem[i] = '0;
      gen_written[i] = 0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    write_period(32'h0004_0000);
    // empty tracks give the default value
    push_sample(0, 1'b0, 32'h0001_2345, 16'h0100);
    push_sample(63, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    // extreme values, coinciding last keys
    push_load(1, 1'b0, 0, 1'b0, 24'd256);
    pending_items[$].value_x = 32'h7FFF_FFFF;
    pending_items[$].value_y = 32'h8000_0000;
    push_load(1, 1'b0, 1, 1'b0, 24'd7680);
    pending_items[$].value_x = 32'h8000_0000;
    pending_items[$].value_y = 32'h7FFF_FFFF;
    push_load(1, 1'b0, 2, 1'b1, 24'd7680);
    push_sample(1, 1'b0, 32'h0, 16'h0100);
    push_sample(1, 1'b0, 32'h0000_8000, 16'h0100);
    push_sample(1, 1'b0, 32'h0001_0000, 16'h0100);
    push_sample(1, 1'b0, 32'h0003_FFFF, 16'hFFFF);
    // single key far away, frame time before the first key
    push_load(63, 1'b1, 0, 1'b1, 24'hFF_FFFF);
    push_sample(63, 1'b1, 32'h0002_0000, 16'h0200);
    // keys out of order
    push_load(2, 1'b1, 0, 1'b0, 24'd100);
    push_load(2, 1'b1, 1, 1'b0, 24'd5000);
    push_load(2, 1'b1, 2, 1'b1, 24'd200);
    push_sample(2, 1'b1, 32'h0000_1000, 16'h0100);
    push_sample(2, 1'b1, 32'h0001_0000, 16'h0100);
    push_sample(2, 1'b1, 32'h0000_0100, 16'h0000);
    // shrink the count back to one key
    push_load(1, 1'b0, 0, 1'b1, 24'd256);
    push_sample(1, 1'b0, 32'h0000_8000, 16'h0100);

    // sender stops until every result is in before each register write
    settle();
    write_period(32'hFFFF_FFFF);
    run_random(150);
    settle();
    write_period(32'h0000_0001);
    send_idle_pct = 57;
    run_random(60);
    settle();
    write_period($urandom_range(1, 32'h0004_0000));
    run_random(190);
    settle();
    write_period(32'h0002_0000);
    send_idle_pct = 0;
    run_random(200);
    settle();

    if (n_errors == 0 && expected_samples.size() == 0) begin
      $display("keyframe_track_interpolator: match");
    end else begin
      $display("keyframe_track_interpolator: mismatch");
    end
    $finish;
  end

endmodule
